[hdl/ptt_pkg.sv]
// Shared types, command codes and sizing constants for the periodic timer table.
package ptt_pkg;

  localparam int SLOTS_DEF   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] timer_id;
    logic [31:0] period;
    logic        has_handler;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        fired;
    logic [31:0] fired_id;
    logic [4:0]  fired_slot;
    logic [31:0] system_time;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] timer_id;
    logic [31:0] period;
    logic        has_handler;
  } job_t;

endpackage

[hdl/periodic_timer_table_top.sv]
// Top level of the periodic timer table: command queue, slot engine and checks.
//
// Input channel (in_valid/in_stall/in_data) takes set, close and tick commands;
// output channel (out_valid/out_stall/out_data) returns result transactions.
// Set, close and unused codes give one result; a tick gives one result per
// reported expiration, in slot order, or one empty result, with last marking the end.
// Commands pass a two-entry queue, so a few may be taken while the slot
// engine works. The engine walks the slots one per cycle, unless a stalled
// output holds it, through the slot RAMs (registered read); a close or tick
// walks all SLOTS entries and a set stops early at the first free slot.
// It takes the next command only once the last one's final result is in
// the output register. Results leave from an output register; while the
// receiver stalls, the engine holds its walk once a second expiration is
// pending, and the queue fills until in_stall rises.
// Reset (rst_n low, synchronous) disables all slots, clears the system time
// and empties the queue and the output register; it needs no clearing pass.
module periodic_timer_table_top #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ptt_pkg::out_t out_data
);

  logic          job_vld;
  logic          job_pop;
  ptt_pkg::job_t job;

  ptt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_vld  (job_vld),
    .job      (job),
    .job_pop  (job_pop)
  );

  ptt_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (job_vld),
    .job       (job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_vld)
    else $error("engine took a command from an empty queue");

  a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.last)
    else $error("non-fire result not marked last");

  a_accept_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.fired)
    else $error("set result also reports an expiration");

endmodule

[hdl/ptt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ptt_front.sv]
// Input stage: classifies each command and holds it in a short queue for the slot engine.
module ptt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptt_pkg::in_t  in_data,
  output logic          job_vld,
  output ptt_pkg::job_t job,
  input  logic          job_pop
);

  localparam int QD  = ptt_pkg::QUEUE_DEPTH;
  localparam int QAW = QD > 1 ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  ptt_pkg::job_t q_r [QD];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  ptt_pkg::job_t  cls;

  function automatic logic [1:0] classify(input logic [1:0] command);
    logic [1:0] op;
    case (command)
      ptt_pkg::CMD_SET:   op = ptt_pkg::OP_SET;
      ptt_pkg::CMD_CLOSE: op = ptt_pkg::OP_CLOSE;
      ptt_pkg::CMD_TICK:  op = ptt_pkg::OP_TICK;
      default:            op = ptt_pkg::OP_NOP;
    endcase
    return op;
  endfunction

  assign in_stall = (cnt_r == QCW'(QD));
  assign push     = in_valid && !in_stall;
  assign job_vld  = (cnt_r != '0);
  assign job      = q_r[rp_r];

  always_comb begin
    cls.op          = classify(in_data.command);
    cls.timer_id    = in_data.timer_id;
    cls.period      = in_data.period;
    cls.has_handler = in_data.has_handler;
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(QD - 1)) ? '0 : wp_r + 1'b1;
    end
    if (job_pop) begin
      rp_nxt = (rp_r == QAW'(QD - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !job_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && job_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

[hdl/ptt_back.sv]
// Slot engine: walks the timer slots one per cycle unless a stalled output holds it, and produces result transactions.
module ptt_back #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_vld,
  input  ptt_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ptt_pkg::out_t out_data
);

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(ptt_pkg::MAX_RESULTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [31:0]      per_r, per_nxt;
  logic             hin_r, hin_nxt;
  logic [31:0]      elapsed_r, elapsed_nxt;
  logic [CW-1:0]    ra_r, ra_nxt;
  logic             b_vld_r, b_vld_nxt;
  logic [IW-1:0]    b_idx_r, b_idx_nxt;
  logic [SLOTS-1:0] en_r, en_nxt;
  logic [SLOTS-1:0] hnd_r, hnd_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [31:0]      pend_id_r, pend_id_nxt;
  logic [4:0]       pend_slot_r, pend_slot_nxt;
  logic             acc_r, acc_nxt;
  logic [4:0]       acc_slot_r, acc_slot_nxt;
  logic             out_vld_r, out_vld_nxt;
  ptt_pkg::out_t    out_r, out_nxt;

  logic [31:0]      own_q, rel_q, rem_q;
  logic             rd_en, set_we, rem_we, set_hit;
  logic [31:0]      rem_wd;
  logic             push;
  ptt_pkg::out_t    push_d;
  logic             out_free, fire_cand, hold;
  logic [IW+4:0]    b_ext;
  logic [4:0]       b_slot5;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || !out_stall;
  assign b_ext     = {5'b0, b_idx_r};
  assign b_slot5   = b_ext[4:0];

  assign fire_cand = b_vld_r && (op_r == ptt_pkg::OP_TICK) && en_r[b_idx_r] &&
                     (rem_q == '0) && hnd_r[b_idx_r] &&
                     (n_r < NW'(ptt_pkg::MAX_RESULTS));
  assign hold      = fire_cand && pend_vld_r && !out_free;

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    per_nxt       = per_r;
    hin_nxt       = hin_r;
    elapsed_nxt   = elapsed_r;
    ra_nxt        = ra_r;
    b_vld_nxt     = b_vld_r;
    b_idx_nxt     = b_idx_r;
    en_nxt        = en_r;
    hnd_nxt       = hnd_r;
    n_nxt         = n_r;
    pend_vld_nxt  = pend_vld_r;
    pend_id_nxt   = pend_id_r;
    pend_slot_nxt = pend_slot_r;
    acc_nxt       = acc_r;
    acc_slot_nxt  = acc_slot_r;
    job_pop       = 1'b0;
    rd_en         = 1'b0;
    set_we        = 1'b0;
    rem_we        = 1'b0;
    rem_wd        = per_r;
    set_hit       = 1'b0;
    push          = 1'b0;
    push_d        = '0;
    push_d.system_time = elapsed_r;

    case (st_r)
      ST_IDLE: begin
        if (job_vld) begin
          job_pop      = 1'b1;
          op_nxt       = job.op;
          id_nxt       = job.timer_id;
          per_nxt      = job.period;
          hin_nxt      = job.has_handler;
          n_nxt        = '0;
          pend_vld_nxt = 1'b0;
          acc_nxt      = 1'b0;
          acc_slot_nxt = '0;
          ra_nxt       = '0;
          b_vld_nxt    = 1'b0;
          if (job.op == ptt_pkg::OP_TICK) begin
            elapsed_nxt = elapsed_r + 32'd1;
          end
          st_nxt = (job.op == ptt_pkg::OP_NOP) ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (!hold) begin
          if (b_vld_r) begin
            case (op_r)
              ptt_pkg::OP_SET: begin
                if (!en_r[b_idx_r]) begin
                  set_we           = 1'b1;
                  rem_we           = 1'b1;
                  rem_wd           = per_r;
                  en_nxt[b_idx_r]  = 1'b1;
                  hnd_nxt[b_idx_r] = hin_r;
                  acc_nxt          = 1'b1;
                  acc_slot_nxt     = b_slot5;
                  set_hit          = 1'b1;
                end
              end
              ptt_pkg::OP_CLOSE: begin
                if (en_r[b_idx_r] && (own_q == id_r)) begin
                  en_nxt[b_idx_r]  = 1'b0;
                  hnd_nxt[b_idx_r] = 1'b0;
                end
              end
              ptt_pkg::OP_TICK: begin
                if (en_r[b_idx_r]) begin
                  rem_we = 1'b1;
                  if (rem_q == '0) begin
                    rem_wd = rel_q;
                  end else begin
                    rem_wd = rem_q - 32'd1;
                  end
                  if (fire_cand) begin
                    n_nxt = n_r + 1'b1;
                    if (pend_vld_r) begin
                      push              = 1'b1;
                      push_d.fired      = 1'b1;
                      push_d.fired_id   = pend_id_r;
                      push_d.fired_slot = pend_slot_r;
                    end
                    pend_vld_nxt  = 1'b1;
                    pend_id_nxt   = own_q;
                    pend_slot_nxt = b_slot5;
                  end
                end
              end
              default: begin
              end
            endcase
          end
          if (set_hit || (b_vld_r && (b_idx_r == IW'(SLOTS - 1)))) begin
            st_nxt    = ST_FIN;
            b_vld_nxt = 1'b0;
          end else if (ra_r < CW'(SLOTS)) begin
            rd_en     = 1'b1;
            b_vld_nxt = 1'b1;
            b_idx_nxt = ra_r[IW-1:0];
            ra_nxt    = ra_r + 1'b1;
          end else begin
            b_vld_nxt = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          push        = 1'b1;
          push_d.last = 1'b1;
          if ((op_r == ptt_pkg::OP_TICK) && pend_vld_r) begin
            push_d.fired      = 1'b1;
            push_d.fired_id   = pend_id_r;
            push_d.fired_slot = pend_slot_r;
          end else begin
            push_d.accepted   = acc_r;
            push_d.fired_slot = acc_slot_r;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    if (push) begin
      out_vld_nxt = 1'b1;
      out_nxt     = push_d;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  ptt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_owner (
    .clk   (clk),
    .we    (set_we),
    .waddr (b_idx_r),
    .wdata (id_r),
    .re    (rd_en),
    .raddr (ra_r[IW-1:0]),
    .rdata (own_q)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_reload (
    .clk   (clk),
    .we    (set_we),
    .waddr (b_idx_r),
    .wdata (per_r),
    .re    (rd_en),
    .raddr (ra_r[IW-1:0]),
    .rdata (rel_q)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_remain (
    .clk   (clk),
    .we    (rem_we),
    .waddr (b_idx_r),
    .wdata (rem_wd),
    .re    (rd_en),
    .raddr (ra_r[IW-1:0]),
    .rdata (rem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      elapsed_r  <= '0;
      ra_r       <= '0;
      b_vld_r    <= 1'b0;
      en_r       <= '0;
      hnd_r      <= '0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      elapsed_r  <= elapsed_nxt;
      ra_r       <= ra_nxt;
      b_vld_r    <= b_vld_nxt;
      en_r       <= en_nxt;
      hnd_r      <= hnd_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    per_r       <= per_nxt;
    hin_r       <= hin_nxt;
    b_idx_r     <= b_idx_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_slot_r <= pend_slot_nxt;
    acc_r       <= acc_nxt;
    acc_slot_r  <= acc_slot_nxt;
    out_r       <= out_nxt;
  end

endmodule

[dv/periodic_timer_table_top_tb.sv]
// Self-checking testbench for the periodic timer table: directed script, random command mix.
module periodic_timer_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_COMMANDS = 135;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * NSLOT + 20;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } script_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit        slot_on[NSLOT];
  bit        slot_reports[NSLOT];
  bit [31:0] slot_id[NSLOT];
  bit [31:0] slot_period[NSLOT];
  bit [31:0] slot_count[NSLOT];
  bit [31:0] ms_now;

  out_t pending_timer_results[$];
  logic [31:0] owner_pool[8];

  int mismatches;
  int results_checked;
  int fires_checked;
  int refused_sets;
  int commands_sent;
  int worst_burst;
  int stall_left;
  bit steady_flow;

  periodic_timer_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic in_t cmd_item(logic [1:0] op, logic [31:0] id, logic [31:0] per,
                                   logic handler);
    in_t c;
    c.command = op;
    c.timer_id = id;
    c.period = per;
    c.has_handler = handler;
    return c;
  endfunction

  function automatic out_t ack(logic acc, logic [4:0] slot, logic [31:0] tm);
    out_t r;
    r = '0;
    r.accepted = acc;
    r.fired_slot = slot;
    r.system_time = tm;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void compute_timer_results(in_t cmd);
    out_t res;
    out_t fires[$];
    int free_slot;
    res = '0;
    free_slot = -1;
    case (cmd.command)
      CMD_SET: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!slot_on[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_on[free_slot] = 1'b1;
          slot_reports[free_slot] = cmd.has_handler;
          slot_id[free_slot] = cmd.timer_id;
          slot_period[free_slot] = cmd.period;
          slot_count[free_slot] = cmd.period;
          res.accepted = 1'b1;
          res.fired_slot = 5'(free_slot);
        end else begin
          refused_sets++;
        end
      end
      CMD_CLOSE: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_id[i] == cmd.timer_id) begin
            slot_on[i] = 1'b0;
            slot_reports[i] = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        ms_now = ms_now + 1;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_on[i]) begin
            if (slot_count[i] == 0) begin
              slot_count[i] = slot_period[i];
              if (slot_reports[i] && fires.size() < MAX_RESULTS) begin
                res.fired = 1'b1;
                res.fired_id = slot_id[i];
                res.fired_slot = 5'(i);
                res.system_time = ms_now;
                fires.push_back(res);
                res = '0;
              end
            end else begin
              slot_count[i] = slot_count[i] - 1;
            end
          end
        end
      end
      default: ;
    endcase
    if (fires.size() == 0) begin
      res.system_time = ms_now;
      res.last = 1'b1;
      pending_timer_results.push_back(res);
    end else begin
      fires[fires.size() - 1].last = 1'b1;
      if (fires.size() > worst_burst) worst_burst = fires.size();
      foreach (fires[k]) pending_timer_results.push_back(fires[k]);
    end
  endfunction

  function automatic void match_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, fname, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    results_checked++;
    if (got.fired) fires_checked++;
    if (pending_timer_results.size() == 0) begin
      $display("%0t: result with none outstanding: %p", $time, got);
      mismatches++;
    end else begin
      want = pending_timer_results.pop_front();
      match_field("accepted", 32'(want.accepted), 32'(got.accepted));
      match_field("fired", 32'(want.fired), 32'(got.fired));
      match_field("fired_id", want.fired_id, got.fired_id);
      match_field("fired_slot", 32'(want.fired_slot), 32'(got.fired_slot));
      match_field("system_time", want.system_time, got.system_time);
      match_field("last", 32'(want.last), 32'(got.last));
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_owner();
    if ($urandom_range(0, 9) < 8) return owner_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_period();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(0, 5);
    if (roll == 7) return $urandom_range(6, 40);
    return $urandom;
  endfunction

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data.timer_id <= $urandom;
      in_data.period <= $urandom;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic send_command(in_t cmd, bit typed = 1'b0, out_t want = '0);
    hold_off(pick_gap());
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall);
    compute_timer_results(cmd);
    if (typed) begin
      void'(pending_timer_results.pop_back());
      pending_timer_results.push_back(want);
    end
    if (cmd.command != CMD_UNUSED) commands_sent++;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, pending_timer_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    script_row_t script[$];
    in_t cmd;
    int kind;
    int burst;
    int base;

    owner_pool[0] = 32'h0000_0000;
    owner_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) begin
      owner_pool[i] = $urandom;
    end

    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b1, ack(0, 0, 1)});
    script.push_back('{cmd_item(CMD_UNUSED, '1, '1, 1), 1'b1, ack(0, 0, 1)});
    script.push_back('{cmd_item(CMD_CLOSE, 0, 0, 0), 1'b1, ack(0, 0, 1)});
    script.push_back('{cmd_item(CMD_SET, '1, 0, 1), 1'b1, ack(1, 0, 1)});
    script.push_back('{cmd_item(CMD_SET, 0, '1, 1), 1'b1, ack(1, 1, 1)});
    script.push_back('{cmd_item(CMD_SET, 5, 1, 1), 1'b1, ack(1, 2, 1)});
    script.push_back('{cmd_item(CMD_SET, 5, 2, 0), 1'b1, ack(1, 3, 1)});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});
    script.push_back('{cmd_item(CMD_TICK, '1, '1, 1), 1'b0, '0});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});
    script.push_back('{cmd_item(CMD_CLOSE, 5, 0, 0), 1'b1, ack(0, 0, 4)});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});
    script.push_back('{cmd_item(CMD_SET, 32'hAAAA_AAAA, 3, 1), 1'b1, ack(1, 2, 5)});
    script.push_back('{cmd_item(CMD_SET, 32'h5555_5555, 0, 1), 1'b1, ack(1, 3, 5)});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});
    script.push_back('{cmd_item(CMD_CLOSE, '1, 0, 0), 1'b1, ack(0, 0, 6)});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});
    script.push_back('{cmd_item(CMD_CLOSE, 32'h1234_5678, 0, 0), 1'b1, ack(0, 0, 7)});
    script.push_back('{cmd_item(CMD_UNUSED, 0, 0, 0), 1'b1, ack(0, 0, 7)});
    script.push_back('{cmd_item(CMD_SET, 0, 0, 0), 1'b1, ack(1, 0, 7)});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});
    script.push_back('{cmd_item(CMD_CLOSE, 0, 0, 0), 1'b1, ack(0, 0, 8)});
    script.push_back('{cmd_item(CMD_TICK, 0, 0, 0), 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) send_command(script[k].item, script[k].typed, script[k].want);

    base = commands_sent;
    while (commands_sent - base < RANDOM_COMMANDS) begin
      steady_flow = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        burst = ($urandom_range(0, 5) == 0) ? NSLOT + 2 : $urandom_range(1, 6);
        repeat (burst) begin
          send_command(cmd_item(CMD_SET, pick_owner(), pick_period(), 1'($urandom)));
        end
      end else if (kind < 7) begin
        repeat ($urandom_range(1, 8)) begin
          send_command(cmd_item(CMD_TICK, $urandom, $urandom, 1'($urandom)));
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 3)) begin
          send_command(cmd_item(CMD_CLOSE, pick_owner(), $urandom, 1'($urandom)));
        end
      end else begin
        cmd = cmd_item(2'($urandom), $urandom, $urandom, 1'($urandom));
        send_command(cmd);
      end
    end
    steady_flow = 1'b0;

    hold_off(1);
    while (pending_timer_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d set/close/tick commands; %0d results checked, %0d of them expirations.",
             commands_sent, results_checked, fires_checked);
    $display("Sets refused on a full table: %0d; largest tick burst: %0d; time reached: %0d ms.",
             refused_sets, worst_burst, ms_now);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
